@@ rtl/core/crcv_pkg.sv @@
// Types, constants and codes for the config record checksum validator.
`default_nettype none

package crcv_pkg;

	localparam int DATA_BYTES = 176;

	localparam logic [7:0] POS_CHECK_HDR  = 8'd2;
	localparam logic [7:0] POS_DATA_FIRST = 8'd3;
	localparam logic [7:0] POS_CHECK_DATA = 8'(POS_DATA_FIRST + DATA_BYTES);

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_VER  = 3'd2;
	localparam logic [2:0] ST_SIZE = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;

	localparam logic CFG_VERSION = 1'b0;
	localparam logic CFG_SIZE    = 1'b1;

	typedef struct packed {
		logic [7:0] record_byte;
		logic       read_error;
	} rec_word_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       data_valid;
		logic       done_res;
		logic [2:0] status;
	} res_word_t;

	typedef struct packed {
		logic [7:0] byte_position;
		logic [7:0] header_sum;
		logic       version_match;
		logic       size_match;
		logic [7:0] data_sum;
	} rec_state_t;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [7:0] expected_size_code;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/config_record_checksum_validator.sv @@
// Top level of the config record checksum validator: registers, handshakes and checks.
//
//  channel  | signals                          | dir | word
//  rec      | rec_valid rec_ready rec_word     | in  | record_byte, read_error
//  res      | res_valid res_ready res_word     | out | data_out, data_valid, done_res, status
//  cfg      | cfg_we cfg_idx cfg_data          | in  | 0 expected_version, 1 expected_size_code
//
// One word per cycle while the result is not stalled; words pass stage 1, then stage 2.
// Stage 1 holds the input word, the evaluation and record state update sit
// in front of the stage 2 result register.
// arst_n clears valids, record state and loads the register reset values.
// A stalled result holds stage 2; stage 1 still takes a word while empty.
`default_nettype none

module config_record_checksum_validator
	import crcv_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        rec_valid,
	output logic       rec_ready,
	input  wire rec_word_t rec_word,
	output logic       res_valid,
	input  wire        res_ready,
	output res_word_t  res_word,
	input  wire        cfg_we,
	input  wire        cfg_idx,
	input  wire [7:0]  cfg_data
);

	logic       v_s1;
	rec_word_t  word_s1;
	logic       v_s2;
	res_word_t  res_s2;
	rec_state_t state_q;
	cfg_t       cfg_q;
	rec_state_t nxt;
	res_word_t  res;
	logic       open_s2;
	logic       adv_s2;

	assign open_s2   = !v_s2 || res_ready;
	assign adv_s2    = v_s1 && open_s2;
	assign rec_ready = !v_s1 || open_s2;
	assign res_valid = v_s2;
	assign res_word  = res_s2;

	crcv_eval u_eval (
		.word (word_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version   <= 8'h02;
			cfg_q.expected_size_code <= 8'h09;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_VERSION: cfg_q.expected_version   <= cfg_data;
				CFG_SIZE:    cfg_q.expected_size_code <= cfg_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rec_ready) begin
			v_s1 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			word_s1 <= rec_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			state_q <= '0;
		end else begin
			if (open_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s2) begin
				state_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	// verdict ends the record
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && res.done_res) |=> (state_q.byte_position == 8'd0))
		else $error("record state not cleared after verdict");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_position <= POS_CHECK_DATA)
		else $error("byte position beyond data check");

	a_data_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.data_valid) |-> (!res_word.done_res &&
		res_word.status == ST_OK))
		else $error("data word carries a verdict");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !res_ready) |=> (v_s1 && $stable(word_s1)))
		else $error("stage 1 word lost under stall");

endmodule

`default_nettype wire

@@ rtl/core/crcv_eval.sv @@
// Per-word evaluation: next record state and result word from one input word.
`default_nettype none

module crcv_eval
	import crcv_pkg::*;
(
	input  wire rec_word_t  word,
	input  wire rec_state_t cur,
	input  wire cfg_t       cfg,
	output rec_state_t      nxt,
	output res_word_t       res
);

	logic [7:0] b;
	logic       err;
	logic [7:0] pos;

	assign b   = word.record_byte;
	assign err = word.read_error;
	assign pos = cur.byte_position;

	always_comb begin
		nxt = cur;
		res = '0;
		priority if (pos < POS_CHECK_HDR) begin
			if (err) begin
				res.done_res = 1'b1;
				res.status   = ST_HDR;
			end else begin
				nxt.header_sum    = cur.header_sum + b;
				nxt.byte_position = pos + 8'd1;
				if (pos == 8'd0) begin
					nxt.version_match = (b == cfg.expected_version);
				end else begin
					nxt.size_match = (b == cfg.expected_size_code);
				end
			end
		end else if (pos == POS_CHECK_HDR) begin
			priority if (err || (~cur.header_sum != b)) begin
				res.done_res = 1'b1;
				res.status   = ST_HDR;
			end else if (!cur.version_match) begin
				res.done_res = 1'b1;
				res.status   = ST_VER;
			end else if (!cur.size_match) begin
				res.done_res = 1'b1;
				res.status   = ST_SIZE;
			end else begin
				nxt.byte_position = POS_DATA_FIRST;
			end
		end else if (pos < POS_CHECK_DATA) begin
			if (err) begin
				res.done_res = 1'b1;
				res.status   = ST_DATA;
			end else begin
				nxt.data_sum      = cur.data_sum + b;
				nxt.byte_position = pos + 8'd1;
				res.data_out      = b;
				res.data_valid    = 1'b1;
			end
		end else begin
			res.done_res = 1'b1;
			res.status   = (err || (~cur.data_sum != b)) ? ST_DATA : ST_OK;
		end
		if (res.done_res) begin
			nxt = '0;
		end
	end

endmodule

`default_nettype wire
